// ===== hw/rtl/tfs_pkg.sv =====
// telemetry frame serializer package
// item and frame types, frame constants; no dependencies
`default_nettype none

package tfs_pkg;

    localparam int SAMPLE_COUNT    = 6;
    localparam int SAMPLE_W        = 16;
    localparam int FRAME_BYTES_MAX = 24;
    localparam int BYTE_IDX_W      = 5;

    localparam logic [7:0] FRAME_HEAD   = 8'hAA;
    localparam logic [7:0] ID_ATTITUDE  = 8'h01;
    localparam logic [7:0] ID_SENSOR    = 8'h02;
    localparam logic [7:0] LEN_ATTITUDE = 8'd12;
    localparam logic [7:0] LEN_SENSOR   = 8'd18;
    localparam int         HEADER_LEN   = 5;

    // configuration register indexes
    localparam logic REG_SOURCE = 1'b0;
    localparam logic REG_DEST   = 1'b1;

    // index of the checksum byte for each frame kind
    localparam logic [BYTE_IDX_W-1:0] LAST_ATTITUDE = BYTE_IDX_W'(17);
    localparam logic [BYTE_IDX_W-1:0] LAST_SENSOR   = BYTE_IDX_W'(23);

    typedef enum logic {
        KIND_ATTITUDE = 1'b0,
        KIND_SENSOR   = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                                 kind;
        logic [SAMPLE_COUNT-1:0][SAMPLE_W-1:0] sample;
    } item_t;

    typedef logic [FRAME_BYTES_MAX-1:0][7:0] frame_bytes_t;

    typedef struct packed {
        logic                  busy;
        logic [BYTE_IDX_W-1:0] idx;
        logic [BYTE_IDX_W-1:0] last_idx;
    } ser_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tfs_cfg_regs.sv =====
// address registers of the telemetry frame serializer
// uses tfs_pkg
`default_nettype none

module tfs_cfg_regs
    import tfs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic       cfg_addr,
    input  wire logic [7:0] cfg_wdata,
    output logic      [7:0] src_addr,
    output logic      [7:0] dst_addr
);

    logic [7:0] src_addr_reg;
    logic [7:0] dst_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_addr_reg <= 8'd5;
            dst_addr_reg <= 8'd175;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_SOURCE: src_addr_reg <= cfg_wdata;
                REG_DEST:   dst_addr_reg <= cfg_wdata;
                default:    src_addr_reg <= src_addr_reg;
            endcase
        end
    end

    assign src_addr = src_addr_reg;
    assign dst_addr = dst_addr_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tfs_frame_builder.sv =====
// formats one item into frame bytes and adds the checksum
// combinational; uses tfs_pkg
`default_nettype none

module tfs_frame_builder
    import tfs_pkg::*;
(
    input  item_t                       item,
    input  wire logic [7:0]             src_addr,
    input  wire logic [7:0]             dst_addr,
    output frame_bytes_t                frame,
    output logic      [BYTE_IDX_W-1:0]  last_idx
);

    frame_bytes_t         body;
    logic [SAMPLE_W-1:0]  yaw_neg;
    logic [7:0]           lvl0 [32];
    logic [7:0]           lvl1 [16];
    logic [7:0]           lvl2 [8];
    logic [7:0]           lvl3 [4];
    logic [7:0]           lvl4 [2];
    logic [7:0]           sum;

    assign yaw_neg = SAMPLE_W'(16'd0 - item.sample[2]);

    always_comb begin
        body    = '0;
        body[0] = FRAME_HEAD;
        body[1] = src_addr;
        body[2] = dst_addr;
        if (item.kind == KIND_SENSOR) begin
            body[3] = ID_SENSOR;
            body[4] = LEN_SENSOR;
            for (int w = 0; w < SAMPLE_COUNT; w++) begin
                body[HEADER_LEN + 2*w]     = item.sample[w][15:8];
                body[HEADER_LEN + 2*w + 1] = item.sample[w][7:0];
            end
        end else begin
            body[3] = ID_ATTITUDE;
            body[4] = LEN_ATTITUDE;
            body[5]  = item.sample[0][15:8];
            body[6]  = item.sample[0][7:0];
            body[7]  = item.sample[1][15:8];
            body[8]  = item.sample[1][7:0];
            body[9]  = yaw_neg[15:8];
            body[10] = yaw_neg[7:0];
        end
    end

    // adder tree over frame bytes 0 to 22; the unused tail is zero
    always_comb begin
        for (int i = 0; i < 32; i++) begin
            lvl0[i] = (i < FRAME_BYTES_MAX - 1) ? body[i % FRAME_BYTES_MAX] : 8'd0;
        end
        for (int i = 0; i < 16; i++) lvl1[i] = lvl0[2*i] + lvl0[2*i+1];
        for (int i = 0; i < 8; i++)  lvl2[i] = lvl1[2*i] + lvl1[2*i+1];
        for (int i = 0; i < 4; i++)  lvl3[i] = lvl2[2*i] + lvl2[2*i+1];
        for (int i = 0; i < 2; i++)  lvl4[i] = lvl3[2*i] + lvl3[2*i+1];
        sum = lvl4[0] + lvl4[1];
    end

    always_comb begin
        frame = body;
        if (item.kind == KIND_SENSOR) begin
            last_idx = LAST_SENSOR;
        end else begin
            last_idx = LAST_ATTITUDE;
        end
        frame[last_idx] = sum;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tfs_byte_serializer.sv =====
// frame register and byte counter that emit one frame byte per transfer
// uses tfs_pkg
`default_nettype none

module tfs_byte_serializer
    import tfs_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   load,
    input  frame_bytes_t                frame,
    input  wire logic [BYTE_IDX_W-1:0]  last_idx,
    output logic                        free,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [7:0]             m_tdata,
    output logic                        m_tlast,
    output ser_status_t                 status
);

    frame_bytes_t          frame_reg;
    logic [BYTE_IDX_W-1:0] last_reg;
    logic [BYTE_IDX_W-1:0] idx_reg;
    logic [BYTE_IDX_W-1:0] idx_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic                  at_last;

    assign at_last = (idx_reg == last_reg);
    // free also in the cycle the checksum byte leaves, so frames follow gap-free
    assign free = !busy_reg || (m_tready && at_last);

    always_comb begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (load) begin
            idx_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg && m_tready) begin
            if (at_last) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            frame_reg <= frame;
            last_reg  <= last_idx;
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = frame_reg[idx_reg];
    assign m_tlast  = busy_reg && at_last;

    assign status.busy     = busy_reg;
    assign status.idx      = idx_reg;
    assign status.last_idx = last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/telemetry_frame_serializer.sv =====
// telemetry frame serializer: one item in, an 18- or 24-byte frame out
// an accepted item goes through the input register, then the frame register, to its first byte
// throughput: one byte per cycle while m_tready is high, set by the byte-wide output;
//   the next item waits in the input register
// reset: aresetn synchronous active low, clears both stages, addresses go to 5 and 175
`default_nettype none

module telemetry_frame_serializer
    import tfs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // sample_0 .. sample_5, 16 bits each, from bit 0 up
    input  wire logic        s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // out_byte
    output logic             m_tlast,   // last_byte
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [7:0]  cfg_wdata
);

    item_t                 in_item_reg;
    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic                  ser_free;
    logic                  ser_load;
    logic                  s_take;
    logic [7:0]            src_addr;
    logic [7:0]            dst_addr;
    frame_bytes_t          frame;
    logic [BYTE_IDX_W-1:0] last_idx;
    ser_status_t           ser_status;

    tfs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .src_addr  (src_addr),
        .dst_addr  (dst_addr)
    );

    assign ser_load = in_valid_reg && ser_free;
    assign s_tready = !in_valid_reg || ser_load;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (ser_load) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg.kind   <= kind_t'(s_tuser);
            in_item_reg.sample <= s_tdata;
        end
    end

    tfs_frame_builder u_build (
        .item     (in_item_reg),
        .src_addr (src_addr),
        .dst_addr (dst_addr),
        .frame    (frame),
        .last_idx (last_idx)
    );

    tfs_byte_serializer u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (ser_load),
        .frame    (frame),
        .last_idx (last_idx),
        .free     (ser_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .status   (ser_status)
    );

    // a waiting item starts its frame right after the previous checksum byte
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast && in_valid_reg) |=> m_tvalid)
        else $error("bubble between back-to-back frames");

    a_frame_len: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_status.busy |-> ((ser_status.last_idx == LAST_ATTITUDE ||
                              ser_status.last_idx == LAST_SENSOR) &&
                             ser_status.idx <= ser_status.last_idx))
        else $error("byte counter outside frame");

    a_item_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take |=> in_valid_reg)
        else $error("accepted item lost");

    a_item_started: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_load |=> (m_tvalid && ser_status.idx == '0))
        else $error("loaded frame did not start at its first byte");

endmodule

`default_nettype wire
